// ===== rtl/core/lsv_pkg.sv =====
`default_nettype none
package lsv_pkg;

    localparam int MAX_DIM   = 32;
    localparam int DIM_W     = 6;
    localparam int CRD_W     = 5;
    localparam int ADDR_W    = 15;
    localparam int VOL_W     = 16;
    localparam int DEPTH     = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int LABEL_W   = 8;
    localparam int FRAC_BITS = 16;
    localparam int POT_W     = 9 + FRAC_BITS;
    localparam int SUM_W     = POT_W + 3;
    localparam int LAMBDA_W  = 16;
    localparam int FACTOR_W  = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // round(2^FRAC_BITS / 6)
    localparam int SIXTH     = ((1 << FRAC_BITS) + 3) / 6;

    localparam logic [LABEL_W-1:0] LABEL_INSIDE = 8'd2;
    localparam logic [LABEL_W-1:0] LABEL_MINUS  = 8'd3;

    typedef logic signed [POT_W-1:0] t_pot;
    typedef logic signed [SUM_W-1:0] t_sum;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_SOLVED = 2'd1,
        ST_POT    = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_INNER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_OUTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA     = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/core/lsv_update.sv =====
`default_nettype none
// Four-stage relaxation datapath: average, difference, scale, saturate.
module lsv_update (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire lsv_pkg::t_sum                 i_sum,
    input  wire lsv_pkg::t_pot                 i_old,
    input  wire logic [lsv_pkg::FACTOR_W-1:0]  i_factor,
    output logic                               o_done,
    output lsv_pkg::t_pot                      o_new
);
    localparam int P1_W  = lsv_pkg::SUM_W + 15;
    localparam int AVG_W = P1_W - lsv_pkg::FRAC_BITS;
    localparam int P2_W  = lsv_pkg::SUM_W + lsv_pkg::FACTOR_W + 1;
    localparam int D_W   = P2_W - 15;
    localparam int N_W   = D_W + 1;

    localparam logic signed [N_W-1:0] POT_MAX = N_W'((1 << (lsv_pkg::POT_W - 1)) - 1);
    localparam logic signed [N_W-1:0] POT_MIN = -POT_MAX - N_W'(1);

    logic [2:0]               r_v;
    logic signed [P1_W-1:0]   r_prod1;
    lsv_pkg::t_pot            r_old1, r_old2, r_old3;
    lsv_pkg::t_sum            r_diff;
    logic signed [P2_W-1:0]   r_prod2;
    logic signed [AVG_W-1:0]  avg;
    logic signed [N_W-1:0]    n_sum;

    always_comb begin
        avg   = AVG_W'(r_prod1 >>> lsv_pkg::FRAC_BITS);
        n_sum = N_W'(r_old3) + N_W'(r_prod2 >>> 15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            o_done <= 1'b0;
        end else begin
            r_v    <= {r_v[1:0], i_start};
            o_done <= r_v[2];
        end
        r_prod1 <= P1_W'(i_sum) * P1_W'($signed({1'b0, 14'(lsv_pkg::SIXTH)}));
        r_old1  <= i_old;
        r_diff  <= lsv_pkg::SUM_W'(avg) - lsv_pkg::SUM_W'(r_old1);
        r_old2  <= r_old1;
        r_prod2 <= P2_W'(r_diff) * P2_W'($signed({1'b0, i_factor}));
        r_old3  <= r_old2;
        if (n_sum > POT_MAX) begin
            o_new <= lsv_pkg::POT_W'(POT_MAX);
        end else if (n_sum < POT_MIN) begin
            o_new <= lsv_pkg::POT_W'(POT_MIN);
        end else begin
            o_new <= lsv_pkg::POT_W'(n_sum);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/laplace_sor_volume_solver_unit.sv =====
`default_nettype none
// Laplace solver over a labelled voxel volume of up to 32x32x32 voxels, held in two
// single-port-read synchronous memories (labels and Q9.16 potentials). A load request
// stores one label and a read request returns one potential. A solve request first
// sets every potential from its label, then runs the configured number of in-place
// sweeps in raster order. A voxel that is not updated is only checked; for an updated
// one, the old value and six neighbours are fetched one per cycle through the single
// potential read port, then pass through the four-stage multiply pipeline before
// write-back. The next voxel is not started until the write lands, so the newest
// values are always read. One request is handled at a time; a finished result waits
// in the output register.
module laplace_sor_volume_solver_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [lsv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lsv_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_cmd,
    input  wire logic [lsv_pkg::ADDR_W-1:0]     i_address,
    input  wire logic [lsv_pkg::LABEL_W-1:0]    i_voxel_label,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [1:0]                          o_status,
    output logic signed [lsv_pkg::POT_W-1:0]    o_potential
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD_WAIT, S_INIT_RD, S_INIT_WR,
        S_SW_LBL, S_SW_CHK, S_SW_NB, S_SW_ACC, S_SW_WAIT
    } t_state;

    localparam int AW = lsv_pkg::ADDR_W;
    localparam int DW = lsv_pkg::DIM_W;
    localparam int CW = lsv_pkg::CRD_W;

    // configuration
    logic [DW-1:0]                   r_dim_inner, r_dim_middle, r_dim_outer;
    logic [15:0]                     r_sweeps;
    logic signed [lsv_pkg::LAMBDA_W-1:0] r_lambda;

    // memories
    logic [lsv_pkg::LABEL_W-1:0] label_mem [lsv_pkg::DEPTH];
    lsv_pkg::t_pot               pot_mem   [lsv_pkg::DEPTH];
    logic [lsv_pkg::LABEL_W-1:0] r_label_rd;
    lsv_pkg::t_pot               r_pot_rd;
    logic [AW-1:0]               pot_raddr;
    logic                        lbl_we, pot_we;
    logic [AW-1:0]               pot_waddr;
    lsv_pkg::t_pot               pot_wdata, init_pot;

    // sequencer
    t_state                r_state;
    logic [AW-1:0]         r_idx, r_plane;
    logic [CW-1:0]         r_x, r_y, r_z;
    logic [15:0]           r_sweep;
    logic [2:0]            r_k;
    logic                  r_nb_v;
    lsv_pkg::t_sum         r_sum;
    lsv_pkg::t_pot         r_old;
    logic [AW-1:0]         nb_addr;

    logic [DW-1:0]         di, dm, dz;
    logic [lsv_pkg::VOL_W-1:0] vol;
    logic                  in_acc, in_range, interior, last_x, last_y, last_z;
    lsv_pkg::t_sum         acc_sum;
    logic                  upd_start, upd_done;
    lsv_pkg::t_pot         upd_new;
    logic [lsv_pkg::FACTOR_W-1:0] factor;

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] d);
        eff_dim = (d > DW'(lsv_pkg::MAX_DIM)) ? DW'(lsv_pkg::MAX_DIM) : d;
    endfunction

    always_comb begin
        di       = eff_dim(r_dim_inner);
        dm       = eff_dim(r_dim_middle);
        dz       = eff_dim(r_dim_outer);
        vol      = lsv_pkg::VOL_W'(di * dm) * lsv_pkg::VOL_W'(dz);
        in_acc   = i_in_valid && !o_in_stall;
        in_range = {1'b0, i_address} < vol;
        factor   = lsv_pkg::FACTOR_W'($signed(r_lambda)) + lsv_pkg::FACTOR_W'(32768);
        last_x   = {1'b0, r_x} == di - DW'(1);
        last_y   = {1'b0, r_y} == dm - DW'(1);
        last_z   = {1'b0, r_z} == dz - DW'(1);
        interior = (r_x != '0) && !last_x && (r_y != '0) && !last_y &&
                   (r_z != '0) && !last_z;
        acc_sum  = r_sum + lsv_pkg::SUM_W'(r_pot_rd);
        case (r_label_rd)
            lsv_pkg::LABEL_INSIDE: init_pot = '0;
            lsv_pkg::LABEL_MINUS:  init_pot = -(lsv_pkg::POT_W'(1) <<< lsv_pkg::FRAC_BITS);
            default: init_pot = lsv_pkg::POT_W'(r_label_rd) <<< lsv_pkg::FRAC_BITS;
        endcase
        case (r_k)
            3'd0:    nb_addr = r_idx - AW'(1);
            3'd1:    nb_addr = r_idx + AW'(1);
            3'd2:    nb_addr = r_idx - AW'(di);
            3'd3:    nb_addr = r_idx + AW'(di);
            3'd4:    nb_addr = r_idx - r_plane;
            default: nb_addr = r_idx + r_plane;
        endcase
        case (r_state)
            S_IDLE:  pot_raddr = i_address;
            S_SW_NB: pot_raddr = nb_addr;
            default: pot_raddr = r_idx;
        endcase
        lbl_we    = in_acc && (i_cmd == lsv_pkg::CMD_LOAD) && in_range;
        pot_we    = (r_state == S_INIT_WR) || (r_state == S_SW_WAIT && upd_done);
        pot_waddr = r_idx;
        pot_wdata = (r_state == S_INIT_WR) ? init_pot : upd_new;
        upd_start = (r_state == S_SW_ACC);
        o_in_stall = (r_state != S_IDLE) || (o_out_valid && i_out_stall);
    end

    // label memory: write on load, read by the solve sequencer
    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            label_mem[i_address] <= i_voxel_label;
        end
        r_label_rd <= label_mem[r_idx];
    end

    // potential memory
    always_ff @(posedge i_clk) begin
        if (pot_we) begin
            pot_mem[pot_waddr] <= pot_wdata;
        end
        r_pot_rd <= pot_mem[pot_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_inner  <= DW'(32);
            r_dim_middle <= DW'(32);
            r_dim_outer  <= DW'(32);
            r_sweeps     <= 16'd100;
            r_lambda     <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lsv_pkg::CFG_DIM_INNER:  r_dim_inner  <= i_cfg_wdata[DW-1:0];
                lsv_pkg::CFG_DIM_MIDDLE: r_dim_middle <= i_cfg_wdata[DW-1:0];
                lsv_pkg::CFG_DIM_OUTER:  r_dim_outer  <= i_cfg_wdata[DW-1:0];
                lsv_pkg::CFG_SWEEPS:     r_sweeps     <= i_cfg_wdata;
                lsv_pkg::CFG_LAMBDA:     r_lambda     <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_nb_v      <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        o_potential <= '0;
                        r_idx       <= '0;
                        r_plane     <= AW'(di * dm);
                        if (i_cmd == lsv_pkg::CMD_SOLVE) begin
                            if (vol == '0) begin
                                o_out_valid <= 1'b1;
                                o_status    <= lsv_pkg::ST_SOLVED;
                            end else begin
                                r_state <= S_INIT_RD;
                            end
                        end else if (i_cmd == lsv_pkg::CMD_READ && in_range) begin
                            r_state <= S_RD_WAIT;
                        end else begin
                            o_out_valid <= 1'b1;
                            o_status    <= (i_cmd == lsv_pkg::CMD_LOAD && in_range) ?
                                           lsv_pkg::ST_STORED : lsv_pkg::ST_RANGE;
                        end
                    end
                end
                S_RD_WAIT: begin
                    o_out_valid <= 1'b1;
                    o_status    <= lsv_pkg::ST_POT;
                    o_potential <= r_pot_rd;
                    r_state     <= S_IDLE;
                end
                S_INIT_RD: begin
                    r_state <= S_INIT_WR;
                end
                S_INIT_WR: begin
                    if ({1'b0, r_idx} == vol - lsv_pkg::VOL_W'(1)) begin
                        r_idx   <= '0;
                        r_x     <= '0;
                        r_y     <= '0;
                        r_z     <= '0;
                        r_sweep <= '0;
                        if (r_sweeps == '0) begin
                            o_out_valid <= 1'b1;
                            o_status    <= lsv_pkg::ST_SOLVED;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_SW_LBL;
                        end
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_INIT_RD;
                    end
                end
                S_SW_LBL: begin
                    r_state <= S_SW_CHK;
                end
                S_SW_CHK: begin
                    r_old  <= r_pot_rd;
                    r_sum  <= '0;
                    r_k    <= '0;
                    r_nb_v <= 1'b0;
                    if (r_label_rd == lsv_pkg::LABEL_INSIDE && interior) begin
                        r_state <= S_SW_NB;
                    end else begin
                        r_state <= S_SW_WAIT;
                    end
                end
                S_SW_NB: begin
                    r_nb_v <= 1'b1;
                    if (r_nb_v) begin
                        r_sum <= acc_sum;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd5) begin
                        r_state <= S_SW_ACC;
                    end
                end
                S_SW_ACC: begin
                    r_sum   <= acc_sum;
                    r_nb_v  <= 1'b0;
                    r_state <= S_SW_WAIT;
                end
                S_SW_WAIT: begin
                    // skipped voxels pass straight through; updated ones wait for write-back
                    if (upd_done || r_k == '0) begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SW_LBL;
                        r_k     <= '0;
                        if (!last_x) begin
                            r_x <= r_x + CW'(1);
                        end else begin
                            r_x <= '0;
                            if (!last_y) begin
                                r_y <= r_y + CW'(1);
                            end else begin
                                r_y <= '0;
                                if (!last_z) begin
                                    r_z <= r_z + CW'(1);
                                end else begin
                                    // end of sweep: rewind or finish
                                    r_z     <= '0;
                                    r_idx   <= '0;
                                    r_sweep <= r_sweep + 16'd1;
                                    if (r_sweep + 16'd1 == r_sweeps) begin
                                        o_out_valid <= 1'b1;
                                        o_status    <= lsv_pkg::ST_SOLVED;
                                        r_state     <= S_IDLE;
                                    end
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lsv_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (upd_start),
        .i_sum    (acc_sum),
        .i_old    (r_old),
        .i_factor (factor),
        .o_done   (upd_done),
        .o_new    (upd_new)
    );

    // hold: potential is zero on every result other than a read
    a_pot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != lsv_pkg::ST_POT |-> o_potential == '0)
        else $error("potential not zero on non-read result");

    // write-back only arrives while the sequencer waits for it
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_done |-> r_state == S_SW_WAIT)
        else $error("update result outside wait state");

    // an update is only launched after all six neighbours were fetched
    a_start_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_start |-> r_k == 3'd6)
        else $error("update started early");

    // an accepted in-range read enters the read-wait state
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_cmd == lsv_pkg::CMD_READ && in_range |=> r_state == S_RD_WAIT)
        else $error("read request not serviced");
endmodule
`default_nettype wire
